// ===== rtl/core/sgfw_pkg.sv =====
// shared constants, font table and glyph helpers for the glyph frame store writer
package sgfw_pkg;

  // panel geometry and scaling
  localparam int GLYPH_SCALE   = 2;
  localparam int PANEL_COLUMNS = 128;
  localparam int PANEL_PAGES   = 8;

  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COUNT = 14;
  localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
  localparam int GLYPH_COL_W = $clog2(GLYPH_COLS);

  localparam int STORE_BYTES = PANEL_COLUMNS * PANEL_PAGES;
  localparam int PANEL_ROWS  = PANEL_PAGES * 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // footprint of one scaled glyph
  localparam int DRAW_COLS  = GLYPH_COLS * GLYPH_SCALE;
  localparam int DRAW_ROWS  = GLYPH_ROWS * GLYPH_SCALE;
  localparam int DCOL_W     = $clog2(DRAW_COLS);
  localparam int ROW_W      = $clog2(DRAW_ROWS);
  // a cell starting anywhere in a page spans at most this many pages
  localparam int PAGE_SPAN  = (DRAW_ROWS + 14) / 8;
  localparam int PAGE_W     = $clog2(PAGE_SPAN);

  // request kinds
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_DRAW  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // glyph table indexes
  localparam logic [GLYPH_IDX_W-1:0] GL_SPACE  = GLYPH_IDX_W'(0);
  localparam logic [GLYPH_IDX_W-1:0] GL_A      = GLYPH_IDX_W'(1);
  localparam logic [GLYPH_IDX_W-1:0] GL_D      = GLYPH_IDX_W'(2);
  localparam logic [GLYPH_IDX_W-1:0] GL_E      = GLYPH_IDX_W'(3);
  localparam logic [GLYPH_IDX_W-1:0] GL_F      = GLYPH_IDX_W'(4);
  localparam logic [GLYPH_IDX_W-1:0] GL_I      = GLYPH_IDX_W'(5);
  localparam logic [GLYPH_IDX_W-1:0] GL_L      = GLYPH_IDX_W'(6);
  localparam logic [GLYPH_IDX_W-1:0] GL_M      = GLYPH_IDX_W'(7);
  localparam logic [GLYPH_IDX_W-1:0] GL_N      = GLYPH_IDX_W'(8);
  localparam logic [GLYPH_IDX_W-1:0] GL_O      = GLYPH_IDX_W'(9);
  localparam logic [GLYPH_IDX_W-1:0] GL_R      = GLYPH_IDX_W'(10);
  localparam logic [GLYPH_IDX_W-1:0] GL_T      = GLYPH_IDX_W'(11);
  localparam logic [GLYPH_IDX_W-1:0] GL_W      = GLYPH_IDX_W'(12);
  localparam logic [GLYPH_IDX_W-1:0] GL_HYPHEN = GLYPH_IDX_W'(13);

  typedef logic [GLYPH_COLS*GLYPH_ROWS-1:0] glyph_bits_t;

  // font, column 0 in the low bits, bit 0 of a column is the top row
  localparam glyph_bits_t GLYPH_ROM [GLYPH_COUNT] = '{
    {7'h00, 7'h00, 7'h00, 7'h00, 7'h00},
    {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E},
    {7'h1C, 7'h22, 7'h41, 7'h41, 7'h7F},
    {7'h41, 7'h49, 7'h49, 7'h49, 7'h7F},
    {7'h01, 7'h09, 7'h09, 7'h09, 7'h7F},
    {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00},
    {7'h40, 7'h40, 7'h40, 7'h40, 7'h7F},
    {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F},
    {7'h7F, 7'h10, 7'h08, 7'h04, 7'h7F},
    {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E},
    {7'h46, 7'h29, 7'h19, 7'h09, 7'h7F},
    {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01},
    {7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F},
    {7'h08, 7'h08, 7'h08, 7'h08, 7'h08}
  };

  // character code to font entry, unknown codes map to space
  function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [7:0] code);
    logic [GLYPH_IDX_W-1:0] idx;
    unique case (code)
      "A":     idx = GL_A;
      "D":     idx = GL_D;
      "E":     idx = GL_E;
      "F":     idx = GL_F;
      "I":     idx = GL_I;
      "L":     idx = GL_L;
      "M":     idx = GL_M;
      "N":     idx = GL_N;
      "O":     idx = GL_O;
      "R":     idx = GL_R;
      "T":     idx = GL_T;
      "W":     idx = GL_W;
      "-":     idx = GL_HYPHEN;
      default: idx = GL_SPACE;
    endcase
    return idx;
  endfunction

  // one font column stretched vertically by the scale factor
  function automatic logic [DRAW_ROWS-1:0] scaled_column(
    input logic [GLYPH_IDX_W-1:0] idx,
    input logic [GLYPH_COL_W-1:0] col
  );
    glyph_bits_t           g;
    logic [GLYPH_ROWS-1:0] c;
    logic [DRAW_ROWS-1:0]  m;
    g = GLYPH_ROM[idx];
    c = g[col*GLYPH_ROWS +: GLYPH_ROWS];
    for (int r = 0; r < DRAW_ROWS; r++) begin
      m[r] = c[r / GLYPH_SCALE];
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/scaled_glyph_framebuffer_writer.sv =====
// frame store with clear, scaled glyph draw and byte read sequencer
// draw: one step per column and page of the scaled cell, one store byte read-modify-written
//   per cycle; read: one store byte is returned as a word
// one item at a time: in_stall stays high until the sequencer is idle again; clear zeroes all STORE_BYTES bytes
// the single write port of the store sets the clear length, one byte per cycle
// reset: a clearing pass zeroes every store byte, in_stall stays high
//   until it ends; no word is produced for it
module scaled_glyph_framebuffer_writer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] pos_x,
  input  logic [7:0] pos_y,
  input  logic [7:0] char_code,
  input  logic [9:0] read_addr,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_DRAW  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam int AW = sgfw_pkg::ADDR_W;

  logic [2:0] state;
  logic       accept;

  // frame store, one write and one read port
  logic [7:0]    frame_mem [sgfw_pkg::STORE_BYTES];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // sequencer registers
  logic [AW-1:0]                    clr_addr;
  logic                             clr_reply;
  logic [7:0]                       px;
  logic [7:0]                       py;
  logic [sgfw_pkg::GLYPH_IDX_W-1:0] gidx;
  logic [sgfw_pkg::DCOL_W-1:0]      col_cnt;
  logic [sgfw_pkg::PAGE_W-1:0]      page_k;
  logic                             rd_ok;
  logic [7:0]                       res_data;

  // write-back stage of the draw pipeline
  logic          wr_valid;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_bits;

  // current draw step
  logic [7:0]    step_x;
  logic [7:0]    step_yb;
  logic          step_on;
  logic [AW-1:0] step_addr;
  logic [7:0]    step_bits;
  logic          step_last_page;
  logic          step_last;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // address, coverage test and pixel byte for one column and page of the cell
  always_comb begin
    logic [sgfw_pkg::DRAW_ROWS-1:0] mask;
    logic [7:0]                     r;
    step_x  = px + 8'(col_cnt);
    step_yb = {py[7:3], 3'b000} + 8'({page_k, 3'b000});
    step_on = ({1'b0, step_x} < 9'(sgfw_pkg::PANEL_COLUMNS)) &&
              ({1'b0, step_yb} < 9'(sgfw_pkg::PANEL_ROWS));
    step_addr = AW'(AW'(step_yb[7:3]) * AW'(sgfw_pkg::PANEL_COLUMNS)) + AW'(step_x);
    mask = sgfw_pkg::scaled_column(gidx,
             sgfw_pkg::GLYPH_COL_W'(col_cnt / sgfw_pkg::GLYPH_SCALE));
    for (int b = 0; b < 8; b++) begin
      r = step_yb + 8'(b) - py;
      step_bits[b] = (r < 8'(sgfw_pkg::DRAW_ROWS)) && mask[r[sgfw_pkg::ROW_W-1:0]];
    end
    step_last_page = (page_k == sgfw_pkg::PAGE_W'(sgfw_pkg::PAGE_SPAN - 1));
    step_last      = step_last_page &&
                     (col_cnt == sgfw_pkg::DCOL_W'(sgfw_pkg::DRAW_COLS - 1));
  end

  // store port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = step_addr;
    if (accept && req_type == sgfw_pkg::REQ_READ) begin
      mem_re    = 1'b1;
      mem_raddr = AW'(read_addr);
    end else if (state == ST_DRAW) begin
      mem_re = step_on;
    end
    priority if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = 8'h00;
    end else begin
      mem_we    = wr_valid;
      mem_waddr = wr_addr;
      mem_wdata = mem_rdata | wr_bits;
    end
  end

  // frame store array
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= frame_mem[mem_raddr];
    end
  end

  // draw write-back stage, steps never revisit a byte
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else begin
      wr_valid <= (state == ST_DRAW) && step_on;
    end
    wr_addr <= step_addr;
    wr_bits <= step_bits;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      col_cnt   <= '0;
      page_k    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res_data <= 8'h00;
            unique case (req_type)
              sgfw_pkg::REQ_CLEAR: begin
                state     <= ST_CLEAR;
                clr_addr  <= '0;
                clr_reply <= 1'b1;
              end
              sgfw_pkg::REQ_DRAW: begin
                state   <= ST_DRAW;
                col_cnt <= '0;
                page_k  <= '0;
              end
              sgfw_pkg::REQ_READ: begin
                state <= ST_READ;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(sgfw_pkg::STORE_BYTES - 1)) begin
            state <= clr_reply ? ST_DONE : ST_IDLE;
          end
        end
        ST_DRAW: begin
          if (step_last_page) begin
            page_k  <= '0;
            col_cnt <= col_cnt + sgfw_pkg::DCOL_W'(1);
          end else begin
            page_k <= page_k + sgfw_pkg::PAGE_W'(1);
          end
          if (step_last) begin
            state <= ST_DONE;
          end
        end
        ST_READ: begin
          res_data <= rd_ok ? mem_rdata : 8'h00;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // captured request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      px    <= pos_x;
      py    <= pos_y;
      gidx  <= sgfw_pkg::glyph_index(char_code);
      rd_ok <= (32'(read_addr) < 32'(sgfw_pkg::STORE_BYTES));
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      read_data <= res_data;
    end
  end

`ifndef SYNTHESIS
  // draw step counters stay inside the cell footprint
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW) |->
      (col_cnt < sgfw_pkg::DCOL_W'(sgfw_pkg::DRAW_COLS)) &&
      (page_k < sgfw_pkg::PAGE_W'(sgfw_pkg::PAGE_SPAN)))
    else $error("draw step counter out of range");

  // write-back only follows a draw step
  assert property (@(posedge clk) disable iff (rst)
    wr_valid |-> $past(state) == ST_DRAW)
    else $error("write-back without a draw step");

  // a new word only appears from the done state
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(state) == ST_DONE)
    else $error("word produced outside done state");
`endif

endmodule
